// ----- rtl/core/ppikbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppikbd_pkg
// Shared types, codes and reset values of the keyboard/switch port block.
// ----------------------------------------------------------------------------
package ppikbd_pkg;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int REQ_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWITCHES     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTR_DELAY   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTR_PULSE   = 2'd3;

    // port offsets inside the window
    localparam logic [1:0] OFS_PORT_A  = 2'd0;
    localparam logic [1:0] OFS_PORT_B  = 2'd1;
    localparam logic [1:0] OFS_PORT_C  = 2'd2;
    localparam logic [1:0] OFS_CONTROL = 2'd3;

    localparam logic [DATA_W-1:0] PORT_B_RESET_BIT  = 8'h40;
    localparam logic [DATA_W-1:0] PORT_B_SELECT_BIT = 8'h08;
    localparam logic [DATA_W-1:0] SELF_TEST_CODE    = 8'hAA;

    localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET = 16'h0060;
    localparam logic [DATA_W-1:0] SWITCHES_RESET     = 8'h3D;
    localparam logic [DATA_W-1:0] INTR_DELAY_RESET   = 8'd10;
    localparam logic [DATA_W-1:0] INTR_PULSE_RESET   = 8'd20;

    // control from the bus side to the interrupt timer
    typedef struct packed {
        logic tick;
        logic arm;
    } intr_ctl_t;

    // port C image: low nibble of switches when port B select bit is set,
    // high nibble otherwise
    function automatic logic [DATA_W-1:0] port_c_from_switches(
        input logic [DATA_W-1:0] port_b,
        input logic [DATA_W-1:0] switches
    );
        logic [DATA_W-1:0] r;
        if ((port_b & PORT_B_SELECT_BIT) != '0)
            r = {4'h0, switches[3:0]};
        else
            r = {4'h0, switches[7:4]};
        return r;
    endfunction

    localparam logic [DATA_W-1:0] PORT_C_RESET =
        port_c_from_switches('0, SWITCHES_RESET);

endpackage : ppikbd_pkg
`default_nettype wire

// ----- rtl/core/ppikbd_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppikbd_ifs
// Valid/ready channels: bus request, result, configuration write.
// ----------------------------------------------------------------------------
interface ppikbd_req_if;
    import ppikbd_pkg::*;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] port_address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, req_type, port_address, write_data, input ready);
    modport sink   (input valid, req_type, port_address, write_data, output ready);
endinterface : ppikbd_req_if

interface ppikbd_rsp_if;
    import ppikbd_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              bad_address;
    logic              intr_level;

    modport source (output valid, read_data, bad_address, intr_level, input ready);
    modport sink   (input valid, read_data, bad_address, intr_level, output ready);
endinterface : ppikbd_rsp_if

interface ppikbd_cfg_if;
    import ppikbd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface : ppikbd_cfg_if
`default_nettype wire

// ----- rtl/core/ppikbd_intr_timer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppikbd_intr_timer
// Delayed keyboard interrupt pulse: delay countdown, then pulse countdown.
// ----------------------------------------------------------------------------
module ppikbd_intr_timer
    import ppikbd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire intr_ctl_t         ctl,
    input  wire logic [DATA_W-1:0] delay_ticks,
    input  wire logic [DATA_W-1:0] pulse_ticks,
    output logic                   line_next
);

    logic              armed_reg, armed_next;
    logic [DATA_W-1:0] cnt_reg, cnt_next;
    logic              line_reg;

    always_comb
    begin
        armed_next = armed_reg;
        cnt_next   = cnt_reg;
        line_next  = line_reg;
        if (ctl.arm)
        begin
            // re-arm: line keeps its level
            armed_next = 1'b1;
            cnt_next   = delay_ticks;
        end
        else if (ctl.tick && armed_reg)
        begin
            if (cnt_reg != '0)
                cnt_next = cnt_reg - 1'b1;
            else if (!line_reg)
            begin
                line_next = 1'b1;
                cnt_next  = pulse_ticks;
            end
            else
            begin
                line_next  = 1'b0;
                armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            cnt_reg   <= '0;
            line_reg  <= 1'b0;
        end
        else
        begin
            armed_reg <= armed_next;
            cnt_reg   <= cnt_next;
            line_reg  <= line_next;
        end
    end

    a_rise_after_delay: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(line_reg) |-> ($past(armed_reg) && $past(cnt_reg) == '0))
        else $error("interrupt rose before delay expired");

    a_fall_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(line_reg) && !$past(ctl.arm)) |-> !armed_reg)
        else $error("interrupt fell but timer still armed");

    a_idle_line_low: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> !line_reg)
        else $error("interrupt high while timer idle");

endmodule : ppikbd_intr_timer
`default_nettype wire

// ----- rtl/core/ppi_keyboard_port_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_keyboard_port_controller
// PC-XT style keyboard/switch parallel port: bus reads, writes and ticks.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   transfer when
//  req      in   req_type, port_address, write_data        req.valid & req.ready
//  rsp      out  read_data, bad_address, intr_level        rsp.valid & rsp.ready
//  cfg      in   index, data                               cfg.valid & cfg.ready
//
//  One item per cycle unless rsp stalls: a request updates latches and timer
//  at the transfer edge and its result is in the output register next cycle.
//  req.ready is high while the output register is empty or being drained,
//  so a stalled rsp holds one result and stops new requests only then.
//  cfg.ready is always high. Reset (rst_n low, async) loads port A with the
//  self-test code and the registers with their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module ppi_keyboard_port_controller
    import ppikbd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    ppikbd_req_if.sink   req,
    ppikbd_rsp_if.source rsp,
    ppikbd_cfg_if.sink   cfg
);

    // configuration registers
    logic [ADDR_W-1:0] base_reg;
    logic [DATA_W-1:0] switches_reg;
    logic [DATA_W-1:0] delay_reg;
    logic [DATA_W-1:0] pulse_reg;

    // port latches
    logic [DATA_W-1:0] port_a_reg, port_a_next;
    logic [DATA_W-1:0] port_b_reg, port_b_next;
    logic [DATA_W-1:0] port_c_reg, port_c_next;
    logic [DATA_W-1:0] ctrl_reg,   ctrl_next;

    // output register
    logic              out_valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              bad_reg;
    logic              intr_reg;

    logic              req_xfer;
    logic              is_rd, is_wr;
    logic [ADDR_W-1:0] offset;
    logic              hit;
    logic [DATA_W-1:0] rd_data;
    logic              bad;
    intr_ctl_t         intr_ctl;
    logic              intr_next;

    assign cfg.ready = 1'b1;
    assign req.ready = !out_valid_reg || rsp.ready;
    assign req_xfer  = req.valid && req.ready;

    // ---------------- configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= BASE_ADDRESS_RESET;
            switches_reg <= SWITCHES_RESET;
            delay_reg    <= INTR_DELAY_RESET;
            pulse_reg    <= INTR_PULSE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BASE_ADDRESS: base_reg     <= cfg.data;
                CFG_SWITCHES:     switches_reg <= cfg.data[DATA_W-1:0];
                CFG_INTR_DELAY:   delay_reg    <= cfg.data[DATA_W-1:0];
                CFG_INTR_PULSE:   pulse_reg    <= cfg.data[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- decode: window is base..base+3, no wrap past 0xFFFF
    assign is_rd  = req.req_type == REQ_READ;
    assign is_wr  = req.req_type == REQ_WRITE;
    assign offset = req.port_address - base_reg;
    assign hit    = (req.port_address >= base_reg) && (offset[ADDR_W-1:2] == '0);

    always_comb
    begin
        port_a_next = port_a_reg;
        port_b_next = port_b_reg;
        port_c_next = port_c_reg;
        ctrl_next   = ctrl_reg;
        rd_data     = '0;
        bad         = (is_rd || is_wr) && !hit;
        intr_ctl    = '{tick: 1'b0, arm: 1'b0};

        if (req_xfer)
        begin
            intr_ctl.tick = req.req_type == REQ_TICK;
            if (is_rd && hit)
            begin
                unique case (offset[1:0])
                    OFS_PORT_A:
                    begin
                        rd_data     = port_a_reg;
                        port_a_next = '0;       // read clears the scan code
                    end
                    OFS_PORT_B:  rd_data = port_b_reg;
                    OFS_PORT_C:  rd_data = port_c_reg;
                    OFS_CONTROL: rd_data = ctrl_reg;
                    default: ;
                endcase
            end
            else if (is_wr && hit)
            begin
                unique case (offset[1:0])
                    OFS_PORT_A: ;               // port A is input only
                    OFS_PORT_B:
                    begin
                        // rising reset bit: port A to self-test code, control cleared, arm timer
                        if ((port_b_reg & PORT_B_RESET_BIT) == '0 &&
                            (req.write_data & PORT_B_RESET_BIT) != '0)
                        begin
                            port_a_next  = SELF_TEST_CODE;
                            ctrl_next    = '0;
                            intr_ctl.arm = 1'b1;
                        end
                        port_b_next = req.write_data;
                        port_c_next = port_c_from_switches(req.write_data, switches_reg);
                    end
                    OFS_PORT_C:  port_c_next = req.write_data;
                    OFS_CONTROL: ctrl_next   = req.write_data;
                    default: ;
                endcase
            end
        end
    end

    ppikbd_intr_timer u_intr_timer (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (intr_ctl),
        .delay_ticks (delay_reg),
        .pulse_ticks (pulse_reg),
        .line_next   (intr_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_a_reg <= SELF_TEST_CODE;
            port_b_reg <= '0;
            port_c_reg <= PORT_C_RESET;
            ctrl_reg   <= '0;
        end
        else
        begin
            port_a_reg <= port_a_next;
            port_b_reg <= port_b_next;
            port_c_reg <= port_c_next;
            ctrl_reg   <= ctrl_next;
        end
    end

    // ---------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (req_xfer)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            rd_data_reg <= rd_data;
            bad_reg     <= bad;
            intr_reg    <= intr_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = rd_data_reg;
    assign rsp.bad_address = bad_reg;
    assign rsp.intr_level  = intr_reg;

    a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_reg) |-> (rd_data_reg == '0))
        else $error("bad address result carries data");

    a_port_a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && is_rd && hit && offset[1:0] == OFS_PORT_A) |=> (port_a_reg == '0))
        else $error("port A not cleared after read");

    a_selftest_load: assert property (@(posedge clk) disable iff (!rst_n)
        intr_ctl.arm |=> (port_a_reg == SELF_TEST_CODE && ctrl_reg == '0))
        else $error("port B reset did not reload latches");

endmodule : ppi_keyboard_port_controller
`default_nettype wire

// ----- bench/ppi_keyboard_port_controller_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_keyboard_port_controller_tb
// Self-checking bench for the keyboard/switch port block. A software image of
// the latches and interrupt timer predicts every result. Bus reads, writes,
// ticks and invalid requests are driven under random idle/stall bursts
// through several register settings. The low and high extremes are included.
// ----------------------------------------------------------------------------
module ppi_keyboard_port_controller_tb;
    import ppikbd_pkg::*;

    // request code that the block must treat as a no-op
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    // cycles with no transfer on any channel before the run is declared hung
    localparam int HANG_LIMIT = 1000;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } bus_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              bad_address;
        logic              intr_level;
    } port_result_t;

    logic clk;
    logic rst_n;

    ppikbd_req_if req ();
    ppikbd_rsp_if rsp ();
    ppikbd_cfg_if cfg ();

    ppi_keyboard_port_controller u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Port image: register settings as the block should hold them, plus the
    // latches and the interrupt timer. Updated only at transfer edges.
    // ------------------------------------------------------------------------
    logic [ADDR_W-1:0] set_base;
    logic [DATA_W-1:0] set_switches;
    logic [DATA_W-1:0] set_delay;
    logic [DATA_W-1:0] set_pulse;

    logic [DATA_W-1:0] img_port_a;
    logic [DATA_W-1:0] img_port_b;
    logic [DATA_W-1:0] img_port_c;
    logic [DATA_W-1:0] img_control;
    logic              img_armed;
    logic [DATA_W-1:0] img_countdown;
    logic              img_intr_line;

    bus_req_t     pending_reqs[$];       // queued stimulus, not yet driven
    port_result_t expected_results[$];   // predicted results, oldest first
    int           reqs_outstanding = 0;  // queued but not yet transferred
    int           mismatches = 0;
    int           idle_odds = 0;         // 1-in-N chance of a burst; 0 = none

    // transfer flags, set at the rising edge, read at the falling edge
    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;
    logic cfg_taken = 1'b0;

    // port C shows one switch nibble, picked by port B bit 3
    function automatic logic [DATA_W-1:0] switch_nibble();
        if ((img_port_b & PORT_B_SELECT_BIT) != '0)
            return {4'h0, set_switches[3:0]};
        return {4'h0, set_switches[7:4]};
    endfunction

    // block reset; the interrupt line keeps its level
    function automatic void restore_latches();
        img_port_a    = SELF_TEST_CODE;
        img_port_b    = '0;
        img_control   = '0;
        img_armed     = 1'b0;
        img_countdown = '0;
        img_port_c    = switch_nibble();
    endfunction

    function automatic void apply_setting(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_BASE_ADDRESS: set_base     = value;
            CFG_SWITCHES:     set_switches = value[DATA_W-1:0];
            CFG_INTR_DELAY:   set_delay    = value[DATA_W-1:0];
            CFG_INTR_PULSE:   set_pulse    = value[DATA_W-1:0];
            default: ;
        endcase
    endfunction

    // Updates the port image for one transfer and returns what the block
    // must answer.
    function automatic port_result_t predict_access(bus_req_t r);
        port_result_t res;
        logic [ADDR_W:0] ofs;
        logic            hit;
        res = '0;
        ofs = {1'b0, r.addr} - {1'b0, set_base};
        // window ends at 0xFFFF; no wrap to low addresses
        hit = (r.addr >= set_base) && (ofs <= 3);
        if (r.kind == REQ_READ || r.kind == REQ_WRITE) begin
            if (!hit) begin
                res.bad_address = 1'b1;
            end else if (r.kind == REQ_READ) begin
                case (ofs[1:0])
                    OFS_PORT_A:
                    begin
                        // read-to-clear scan code
                        res.read_data = img_port_a;
                        img_port_a    = '0;
                    end
                    OFS_PORT_B: res.read_data = img_port_b;
                    OFS_PORT_C: res.read_data = img_port_c;
                    default:    res.read_data = img_control;
                endcase
            end else begin
                case (ofs[1:0])
                    OFS_PORT_A: ;
                    OFS_PORT_B:
                    begin
                        // rising keyboard-reset bit: reset latches, arm timer
                        if ((img_port_b & PORT_B_RESET_BIT) == '0 &&
                            (r.data & PORT_B_RESET_BIT) != '0) begin
                            restore_latches();
                            img_armed     = 1'b1;
                            img_countdown = set_delay;
                        end
                        img_port_b = r.data;
                        img_port_c = switch_nibble();
                    end
                    OFS_PORT_C: img_port_c  = r.data;
                    default:    img_control = r.data;
                endcase
            end
        end else if (r.kind == REQ_TICK && img_armed) begin
            if (img_countdown != '0) begin
                img_countdown = img_countdown - 8'd1;
            end else if (!img_intr_line) begin
                img_intr_line = 1'b1;
                img_countdown = set_pulse;
            end else begin
                // falls and disarms, also when re-armed while high
                img_intr_line = 1'b0;
                img_armed     = 1'b0;
            end
        end
        res.intr_level = img_intr_line;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: request channel and response back-pressure, falling edge.
    // ------------------------------------------------------------------------
    int req_gap   = 0;
    int rsp_stall = 0;

    always @(negedge clk)
    begin
        bus_req_t nxt;
        logic     send;
        send = 1'b0;
        nxt  = '0;
        if (rst_n) begin
            // a presented request holds until its transfer
            if (!req.valid || req_taken) begin
                if (req_gap > 0)
                    req_gap--;
                else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                    req_gap = $urandom_range(1, 9) - 1;
                else if (pending_reqs.size() != 0) begin
                    nxt  = pending_reqs.pop_front();
                    send = 1'b1;
                end
                req.valid <= send;
                if (send) begin
                    req.req_type     <= nxt.kind;
                    req.port_address <= nxt.addr;
                    req.write_data   <= nxt.data;
                end
            end

            if (rsp_stall > 0) begin
                rsp_stall--;
                rsp.ready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                rsp_stall = $urandom_range(1, 9) - 1;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: rising edge. Results are checked before new predictions are
    // queued; a result never comes out in its own request's transfer cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        port_result_t want;
        port_result_t got;
        req_taken = 1'b0;
        rsp_taken = 1'b0;
        cfg_taken = 1'b0;
        if (rst_n) begin
            req_taken = req.valid && req.ready;
            rsp_taken = rsp.valid && rsp.ready;
            cfg_taken = cfg.valid && cfg.ready;

            if (rsp_taken) begin
                got.read_data   = rsp.read_data;
                got.bad_address = rsp.bad_address;
                got.intr_level  = rsp.intr_level;
                if (expected_results.size() == 0) begin
                    $error("result transfer with no request waiting for one");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data) begin
                        $error("read_data: expected %0h, got %0h",
                               want.read_data, got.read_data);
                        mismatches++;
                    end
                    if (got.bad_address !== want.bad_address) begin
                        $error("bad_address: expected %0b, got %0b",
                               want.bad_address, got.bad_address);
                        mismatches++;
                    end
                    if (got.intr_level !== want.intr_level) begin
                        $error("intr_level: expected %0b, got %0b",
                               want.intr_level, got.intr_level);
                        mismatches++;
                    end
                end
            end

            if (cfg_taken)
                apply_setting(cfg.index, cfg.data);

            if (req_taken) begin
                expected_results.push_back(predict_access(
                    '{kind: req.req_type, addr: req.port_address, data: req.write_data}));
                reqs_outstanding--;
            end
        end
    end

    // watchdog: any transfer restarts the count
    int hang_count = 0;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req.valid && req.ready || rsp.valid && rsp.ready || cfg.valid && cfg.ready)
                hang_count = 0;
            else
                hang_count++;
            if (hang_count >= HANG_LIMIT) begin
                $display("[ppi_keyboard_port_controller] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_req(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr,
                             logic [DATA_W-1:0] data);
        pending_reqs.push_back('{kind: kind, addr: addr, data: data});
        reqs_outstanding++;
    endtask

    // returns at a falling edge once every request has been answered
    task automatic wait_idle();
        while (reqs_outstanding != 0 || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // writes all four registers back to back; called at a falling edge
    task automatic load_settings(logic [ADDR_W-1:0] base, logic [DATA_W-1:0] switches,
                                 logic [DATA_W-1:0] delay, logic [DATA_W-1:0] pulse);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [CFG_DATA_W-1:0]  val [4];
        idx = '{CFG_BASE_ADDRESS, CFG_SWITCHES, CFG_INTR_DELAY, CFG_INTR_PULSE};
        val = '{base, {8'h00, switches}, {8'h00, delay}, {8'h00, pulse}};
        cfg.valid <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            cfg.index <= idx[i];
            cfg.data  <= val[i];
            do
                @(negedge clk);
            while (!cfg_taken);
        end
        cfg.valid <= 1'b0;
    endtask

    // Random mix: mostly in-window accesses and ticks so the keyboard-reset
    // and interrupt sequences run often; the rest misses the window or is
    // junk.
    task automatic queue_random(int count);
        logic [ADDR_W-1:0] addr;
        int                pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0:       addr = set_base - 16'd1;
                1:       addr = set_base + 16'd4;
                default: addr = ADDR_W'($urandom_range(0, 65535));
            endcase
            if (pick < 35)
                queue_req(REQ_TICK, ADDR_W'($urandom_range(0, 65535)),
                          DATA_W'($urandom_range(0, 255)));
            else if (pick < 55)
                queue_req(REQ_READ, set_base + ADDR_W'($urandom_range(0, 3)),
                          DATA_W'($urandom_range(0, 255)));
            else if (pick < 80)
                queue_req(REQ_WRITE, set_base + ADDR_W'($urandom_range(0, 3)),
                          DATA_W'($urandom_range(0, 255)));
            else if (pick < 90)
                queue_req($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, addr,
                          DATA_W'($urandom_range(0, 255)));
            else if (pick < 95)
                queue_req(REQ_UNUSED, ADDR_W'($urandom_range(0, 65535)),
                          DATA_W'($urandom_range(0, 255)));
            else
                queue_req(REQ_W'($urandom_range(0, 3)), ADDR_W'($urandom_range(0, 65535)),
                          DATA_W'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.req_type     = REQ_READ;
        req.port_address = '0;
        req.write_data   = '0;
        rsp.ready        = 1'b0;
        cfg.valid        = 1'b0;
        cfg.index        = CFG_BASE_ADDRESS;
        cfg.data         = '0;

        set_base      = BASE_ADDRESS_RESET;
        set_switches  = SWITCHES_RESET;
        set_delay     = INTR_DELAY_RESET;
        set_pulse     = INTR_PULSE_RESET;
        img_intr_line = 1'b0;
        img_port_b    = '0;
        restore_latches();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: self-test code read then cleared, other latches
        idle_odds = 4;
        queue_req(REQ_READ,  16'h0060, 8'h00);
        queue_req(REQ_READ,  16'h0060, 8'h00);
        queue_req(REQ_READ,  16'h0061, 8'h00);
        queue_req(REQ_READ,  16'h0062, 8'h00);
        // port A writes are dropped; port C and control store the byte
        queue_req(REQ_WRITE, 16'h0060, 8'hFF);
        queue_req(REQ_READ,  16'h0060, 8'h00);
        queue_req(REQ_WRITE, 16'h0062, 8'hFF);
        queue_req(REQ_READ,  16'h0062, 8'h00);
        queue_req(REQ_WRITE, 16'h0063, 8'h9B);
        queue_req(REQ_READ,  16'h0063, 8'h00);
        // select bit flips port C to the low switch nibble
        queue_req(REQ_WRITE, 16'h0061, 8'h08);
        queue_req(REQ_READ,  16'h0062, 8'h00);
        // keyboard reset through port B bit 6, then bit 6 held (no new edge)
        queue_req(REQ_WRITE, 16'h0061, 8'h48);
        queue_req(REQ_READ,  16'h0060, 8'h00);
        queue_req(REQ_WRITE, 16'h0061, 8'h40);
        // just outside the window on both sides, and unused request code
        queue_req(REQ_READ,  16'h005F, 8'h00);
        queue_req(REQ_WRITE, 16'h0064, 8'hFF);
        queue_req(REQ_WRITE, 16'hFFFF, 8'hFF);
        queue_req(REQ_UNUSED, 16'h0060, 8'hFF);
        queue_req(REQ_TICK,  16'h0000, 8'h00);
        wait_idle();

        // low extremes: zero delay and pulse, window at address zero
        load_settings(16'h0000, 8'h00, 8'd0, 8'd0);
        queue_req(REQ_WRITE, 16'h0001, 8'h00);
        queue_req(REQ_WRITE, 16'h0001, 8'h40);
        queue_req(REQ_TICK,  16'h0000, 8'h00);
        queue_req(REQ_TICK,  16'h0000, 8'h00);
        queue_req(REQ_WRITE, 16'h0001, 8'h00);
        queue_req(REQ_WRITE, 16'h0001, 8'h40);
        queue_req(REQ_TICK,  16'h0000, 8'h00);
        // re-arm while the line is high: next tick drops it, no new pulse
        queue_req(REQ_WRITE, 16'h0001, 8'h00);
        queue_req(REQ_WRITE, 16'h0001, 8'h40);
        queue_req(REQ_TICK,  16'h0000, 8'h00);
        queue_req(REQ_READ,  16'hFFFF, 8'h00);
        wait_idle();

        // high extremes: window at the top of the address space, no wrap
        load_settings(16'hFFFC, 8'hFF, 8'd255, 8'd255);
        queue_req(REQ_READ,  16'hFFFF, 8'h00);
        queue_req(REQ_READ,  16'h0000, 8'h00);
        queue_req(REQ_READ,  16'hFFFB, 8'h00);
        queue_random(150);
        wait_idle();

        // random settings; short timer values so pulses complete often
        for (int phase = 0; phase < 7; phase++) begin
            idle_odds = (phase % 3 == 2) ? 0 : ((phase % 3 == 0) ? 4 : 10);
            load_settings(ADDR_W'($urandom_range(0, 65532)), DATA_W'($urandom_range(0, 255)),
                          DATA_W'($urandom_range(0, 12)), DATA_W'($urandom_range(0, 12)));
            queue_random(200);
            wait_idle();
        end

        // closing stretch at full rate
        idle_odds = 0;
        load_settings(BASE_ADDRESS_RESET, DATA_W'($urandom_range(0, 255)), 8'd3, 8'd2);
        queue_random(100);
        wait_idle();

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("[ppi_keyboard_port_controller] OK");
        else
            $display("[ppi_keyboard_port_controller] ERROR");
        $finish;
    end

endmodule
